@@ sv/direction_gain_pid_position_macros.svh @@
// assertion helpers shared by the controller files
`ifndef DIRECTION_GAIN_PID_POSITION_MACROS_SVH
`define DIRECTION_GAIN_PID_POSITION_MACROS_SVH

// same-cycle implication, masked while dis is high
`define DGPID_ASSERT_NOW(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("dgpid: same-cycle check failed");

// next-cycle implication, masked while dis is high
`define DGPID_ASSERT_NEXT(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("dgpid: next-cycle check failed");

`endif

@@ sv/dgpid_pkg.sv @@
`default_nettype none

package dgpid_pkg;

  localparam int GAIN_BITS      = 24;
  localparam int GAIN_FRAC      = 8;
  localparam int COUNT_BITS     = 32;
  localparam int DRIVE_BITS     = 16;
  localparam int FULL_SCALE     = 16384;
  localparam int REG_INDEX_BITS = 3;

  // configuration register map
  typedef enum logic [REG_INDEX_BITS-1:0] {
    REG_KP_DOWN = 3'd0,
    REG_KI_DOWN = 3'd1,
    REG_KD_DOWN = 3'd2,
    REG_KP_UP   = 3'd3,
    REG_KI_UP   = 3'd4,
    REG_KD_UP   = 3'd5
  } gain_reg_t;

  typedef logic signed [GAIN_BITS-1:0] gain_t;

  typedef struct packed {
    gain_t kp;
    gain_t ki;
    gain_t kd;
  } gain_set_t;

  typedef struct packed {
    logic signed [COUNT_BITS-1:0] target_count;
    logic signed [COUNT_BITS-1:0] measured_count;
  } sample_t;

  typedef struct packed {
    logic signed [DRIVE_BITS-1:0] motor_drive;
    logic                         clamped;
  } result_t;

  localparam logic signed [DRIVE_BITS-1:0] DRIVE_MAX = 16'sd16384;
  localparam logic signed [DRIVE_BITS-1:0] DRIVE_MIN = -16'sd16384;

endpackage

`default_nettype wire

@@ sv/direction_gain_pid_position.sv @@
`default_nettype none
`include "direction_gain_pid_position_macros.svh"

// pid position controller with separate up and down gain sets and an output clamp.
// each sample word carries a target and a measured encoder count; the low
// POSITION_BITS of each are used, sign-extended. the down gains apply when the
// target is at or below the measured position, the up gains otherwise. the error
// feeds a saturating INTEGRAL_BITS-wide sum (no anti-windup) and a difference
// from the previous error; kp*e + ki*sum + kd*diff is formed exactly, the 8 gain
// fraction bits are dropped (rounding toward minus infinity), the value is
// clamped to +-16384 (full scale 1.0) and the negated drive goes out together
// with a clamp flag. gains are to be written through cfg_write/cfg_index/cfg_data
// only while the block is idle; the block itself does not enforce this. indexes
// past the six gain registers are ignored. every accepted sample gives exactly
// one result word, which passes the input, error, product, partial-sum and
// output stages in turn. a new sample is taken every cycle unless stalled: the
// only loop is the error/integral update, one subtract and one saturating add,
// and the products and final sum run in the registered stages behind it. the
// ki*sum product is split into two half-width multiplies. empty stages
// collapse, so the sample side stalls only when all five stages hold words.

module direction_gain_pid_position #(
  parameter int POSITION_BITS = 32,
  parameter int INTEGRAL_BITS = 48
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [dgpid_pkg::REG_INDEX_BITS-1:0]   cfg_index,
  input  logic [dgpid_pkg::GAIN_BITS-1:0]        cfg_data,
  input  logic                                   sample_valid,
  output logic                                   sample_stall,
  input  dgpid_pkg::sample_t                     sample,
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output dgpid_pkg::result_t                     result
);

  import dgpid_pkg::*;

  localparam int ERR_BITS    = POSITION_BITS + 1;
  localparam int DIFF_BITS   = POSITION_BITS + 2;
  localparam int SUM_LO_BITS = INTEGRAL_BITS / 2;
  localparam int SUM_HI_BITS = INTEGRAL_BITS - SUM_LO_BITS;
  localparam int P_BITS      = GAIN_BITS + ERR_BITS;
  localparam int D_BITS      = GAIN_BITS + DIFF_BITS;
  localparam int ILO_BITS    = GAIN_BITS + SUM_LO_BITS + 1;
  localparam int IHI_BITS    = GAIN_BITS + SUM_HI_BITS;
  // three exact products summed; the integral term is the widest
  localparam int ACC_BITS    = GAIN_BITS + INTEGRAL_BITS + 2;
  localparam int SHIFT_BITS  = ACC_BITS - GAIN_FRAC;
  localparam logic signed [SHIFT_BITS-1:0] POS_LIMIT = SHIFT_BITS'(FULL_SCALE);
  localparam logic signed [SHIFT_BITS-1:0] NEG_LIMIT = SHIFT_BITS'(-FULL_SCALE);

  // gain registers
  gain_set_t gains_down;
  gain_set_t gains_up;

  always_ff @(posedge clk) begin
    if (rst) begin
      gains_down <= '0;
      gains_up   <= '0;
    end else if (cfg_write) begin
      case (gain_reg_t'(cfg_index))
        REG_KP_DOWN: gains_down.kp <= cfg_data;
        REG_KI_DOWN: gains_down.ki <= cfg_data;
        REG_KD_DOWN: gains_down.kd <= cfg_data;
        REG_KP_UP:   gains_up.kp   <= cfg_data;
        REG_KI_UP:   gains_up.ki   <= cfg_data;
        REG_KD_UP:   gains_up.kd   <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage occupancy and flow control: a stage moves when the next one is
  // empty or moving, so bubbles close up
  logic v1, v2, v3, v4;
  logic ready1, ready2, ready3, ready4, ready5;

  always_comb begin
    ready5 = !result_valid || !result_stall;
    ready4 = !v4 || ready5;
    ready3 = !v3 || ready4;
    ready2 = !v2 || ready3;
    ready1 = !v1 || ready2;
  end

  assign sample_stall = !ready1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      v4           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (ready1) begin
        v1 <= sample_valid;
      end
      if (ready2) begin
        v2 <= v1;
      end
      if (ready3) begin
        v3 <= v2;
      end
      if (ready4) begin
        v4 <= v3;
      end
      if (ready5) begin
        result_valid <= v4;
      end
    end
  end

  // stage 1: input register
  logic signed [POSITION_BITS-1:0] target_q;
  logic signed [POSITION_BITS-1:0] measured_q;

  always_ff @(posedge clk) begin
    if (ready1 && sample_valid) begin
      target_q   <= sample.target_count[POSITION_BITS-1:0];
      measured_q <= sample.measured_count[POSITION_BITS-1:0];
    end
  end

  // stage 2: error, integral and difference; gain set picked by direction
  logic                            load_error;
  logic signed [ERR_BITS-1:0]      err;
  logic signed [INTEGRAL_BITS-1:0] error_sum;
  logic signed [DIFF_BITS-1:0]     diff;
  gain_set_t                       gains_q;

  assign load_error = v1 && ready2;

  dgpid_error #(
    .POSITION_BITS(POSITION_BITS),
    .INTEGRAL_BITS(INTEGRAL_BITS)
  ) u_error (
    .clk      (clk),
    .rst      (rst),
    .load     (load_error),
    .target   (target_q),
    .measured (measured_q),
    .err      (err),
    .error_sum(error_sum),
    .diff     (diff)
  );

  // equal positions take the down set
  always_ff @(posedge clk) begin
    if (load_error) begin
      gains_q <= (target_q <= measured_q) ? gains_down : gains_up;
    end
  end

  // stage 3: products, ki*sum split into low (unsigned) and high (signed) halves
  logic signed [P_BITS-1:0]   prod_p;
  logic signed [D_BITS-1:0]   prod_d;
  logic signed [ILO_BITS-1:0] prod_ilo;
  logic signed [IHI_BITS-1:0] prod_ihi;

  always_ff @(posedge clk) begin
    if (v2 && ready3) begin
      prod_p   <= $signed(gains_q.kp) * err;
      prod_d   <= $signed(gains_q.kd) * diff;
      prod_ilo <= $signed(gains_q.ki) * $signed({1'b0, error_sum[SUM_LO_BITS-1:0]});
      prod_ihi <= $signed(gains_q.ki) * $signed(error_sum[INTEGRAL_BITS-1:SUM_LO_BITS]);
    end
  end

  // stage 4: two partial sums
  logic signed [ACC_BITS-1:0] sum_pd;
  logic signed [ACC_BITS-1:0] sum_i;

  always_ff @(posedge clk) begin
    if (v3 && ready4) begin
      sum_pd <= ACC_BITS'(prod_p) + ACC_BITS'(prod_d);
      sum_i  <= (ACC_BITS'(prod_ihi) <<< SUM_LO_BITS) + ACC_BITS'(prod_ilo);
    end
  end

  // stage 5: final add, drop gain fraction, clamp, negate
  logic signed [ACC_BITS-1:0]   total;
  logic signed [SHIFT_BITS-1:0] scaled;
  logic signed [DRIVE_BITS-1:0] drive;
  result_t                      result_next;

  always_comb begin
    total  = sum_pd + sum_i;
    scaled = total[ACC_BITS-1:GAIN_FRAC];
    result_next.clamped = 1'b1;
    if (scaled > POS_LIMIT) begin
      drive = DRIVE_MAX;
    end else if (scaled < NEG_LIMIT) begin
      drive = DRIVE_MIN;
    end else begin
      drive = scaled[DRIVE_BITS-1:0];
      result_next.clamped = 1'b0;
    end
    result_next.motor_drive = -drive;
  end

  always_ff @(posedge clk) begin
    if (v4 && ready5) begin
      result <= result_next;
    end
  end

  `DGPID_ASSERT_NOW(a_stall_only_full, clk, rst, sample_stall, v1 && v2 && v3 && v4 && result_valid && result_stall)
  `DGPID_ASSERT_NOW(a_clamp_at_limit, clk, rst, result_valid && result.clamped, result.motor_drive == DRIVE_MAX || result.motor_drive == DRIVE_MIN)
  `DGPID_ASSERT_NEXT(a_empty_after_reset, clk, 1'b0, rst, !result_valid && !v1 && !v4)

endmodule

`default_nettype wire

@@ sv/dgpid_error.sv @@
`default_nettype none
`include "direction_gain_pid_position_macros.svh"

module dgpid_error #(
  parameter int POSITION_BITS = 32,
  parameter int INTEGRAL_BITS = 48
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            load,
  input  logic signed [POSITION_BITS-1:0] target,
  input  logic signed [POSITION_BITS-1:0] measured,
  output logic signed [POSITION_BITS:0]   err,
  output logic signed [INTEGRAL_BITS-1:0] error_sum,
  output logic signed [POSITION_BITS+1:0] diff
);

  localparam int ERR_BITS  = POSITION_BITS + 1;
  localparam int DIFF_BITS = POSITION_BITS + 2;
  localparam logic signed [INTEGRAL_BITS-1:0] SUM_MAX = {1'b0, {(INTEGRAL_BITS-1){1'b1}}};
  localparam logic signed [INTEGRAL_BITS-1:0] SUM_MIN = {1'b1, {(INTEGRAL_BITS-1){1'b0}}};

  logic signed [ERR_BITS-1:0]      err_next;
  logic signed [INTEGRAL_BITS:0]   sum_wide;
  logic                            sum_over;
  logic signed [INTEGRAL_BITS-1:0] error_sum_next;
  logic signed [DIFF_BITS-1:0]     diff_next;
  logic signed [ERR_BITS-1:0]      previous_error;

  always_comb begin
    err_next = ERR_BITS'(target) - ERR_BITS'(measured);
    sum_wide = (INTEGRAL_BITS+1)'(error_sum) + (INTEGRAL_BITS+1)'(err_next);
    // top two bits disagree: the sum left the signed range, so stick at the limit
    sum_over = sum_wide[INTEGRAL_BITS] != sum_wide[INTEGRAL_BITS-1];
    if (sum_over) begin
      error_sum_next = sum_wide[INTEGRAL_BITS] ? SUM_MIN : SUM_MAX;
    end else begin
      error_sum_next = sum_wide[INTEGRAL_BITS-1:0];
    end
    diff_next = DIFF_BITS'(err_next) - DIFF_BITS'(previous_error);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum      <= '0;
      previous_error <= '0;
    end else if (load) begin
      error_sum      <= error_sum_next;
      previous_error <= err_next;
    end
  end

  // diff only travels with the word, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      diff <= diff_next;
    end
  end

  // the updated error is the one the downstream terms use
  assign err = previous_error;

  `DGPID_ASSERT_NEXT(a_sum_holds_high, clk, rst, load && error_sum == SUM_MAX && !err_next[ERR_BITS-1], error_sum == SUM_MAX)
  `DGPID_ASSERT_NEXT(a_sum_holds_low, clk, rst, load && error_sum == SUM_MIN && err_next[ERR_BITS-1], error_sum == SUM_MIN)
  `DGPID_ASSERT_NEXT(a_state_idle, clk, rst, !load, $stable(error_sum) && $stable(previous_error))

endmodule

`default_nettype wire

@@ verif/direction_gain_pid_position_checker.sv @@
`timescale 1ns / 1ps

// watches the gain port and both word channels, predicts each drive word and compares
module direction_gain_pid_position_checker #(
  parameter int POSITION_BITS = 32,
  parameter int INTEGRAL_BITS = 48
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [dgpid_pkg::REG_INDEX_BITS-1:0] cfg_index,
  input  logic [dgpid_pkg::GAIN_BITS-1:0]      cfg_data,
  input  logic                                 sample_valid,
  input  logic                                 sample_stall,
  input  dgpid_pkg::sample_t                   sample,
  input  logic                                 result_valid,
  input  logic                                 result_stall,
  input  dgpid_pkg::result_t                   result,
  output int                                   mismatches,
  output int                                   outstanding
);

  import dgpid_pkg::*;

  gain_t              gain_bank [6];
  logic signed [127:0] integral;
  logic signed [127:0] prev_err;
  result_t            expected_drives [$];

  task automatic predict_drive(input sample_t s, output result_t r);
    logic signed [127:0] tgt;
    logic signed [127:0] meas;
    logic signed [127:0] err;
    logic signed [127:0] total;
    logic signed [127:0] diff;
    logic signed [127:0] sum_hi;
    logic signed [127:0] sum_lo;
    logic signed [127:0] acc;
    logic signed [DRIVE_BITS-1:0] drive;
    int base;
    tgt  = $signed(s.target_count);
    meas = $signed(s.measured_count);
    tgt  = (tgt <<< (128 - POSITION_BITS)) >>> (128 - POSITION_BITS);
    meas = (meas <<< (128 - POSITION_BITS)) >>> (128 - POSITION_BITS);
    // ties go to the down set
    base = (tgt <= meas) ? REG_KP_DOWN : REG_KP_UP;
    err  = tgt - meas;
    // integral saturates, no wrap
    sum_hi = (128'sd1 <<< (INTEGRAL_BITS - 1)) - 128'sd1;
    sum_lo = -sum_hi - 128'sd1;
    total  = integral + err;
    if (total > sum_hi) integral = sum_hi;
    else if (total < sum_lo) integral = sum_lo;
    else integral = total;
    diff = err - prev_err;
    prev_err = err;
    acc = gain_bank[base] * err + gain_bank[base + 1] * integral
        + gain_bank[base + 2] * diff;
    acc = acc >>> GAIN_FRAC;
    r.clamped = 1'b0;
    if (acc > FULL_SCALE) begin
      drive = DRIVE_MAX;
      r.clamped = 1'b1;
    end else if (acc < -FULL_SCALE) begin
      drive = DRIVE_MIN;
      r.clamped = 1'b1;
    end else begin
      drive = acc[DRIVE_BITS-1:0];
    end
    r.motor_drive = -drive;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      foreach (gain_bank[i]) gain_bank[i] = '0;
      integral = '0;
      prev_err = '0;
      expected_drives.delete();
      mismatches = 0;
    end else begin
      if (cfg_write && cfg_index <= REG_KD_UP) gain_bank[cfg_index] = cfg_data;
      if (result_valid && !result_stall) begin
        if (expected_drives.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result word: drive %0d clamped %0b",
                   $time, result.motor_drive, result.clamped);
        end else begin
          want = expected_drives.pop_front();
          if (result.motor_drive !== want.motor_drive || result.clamped !== want.clamped) begin
            mismatches++;
            $display("%0t: mismatch: expected drive %0d clamped %0b, got drive %0d clamped %0b",
                     $time, want.motor_drive, want.clamped,
                     result.motor_drive, result.clamped);
          end
        end
      end
      if (sample_valid && !sample_stall) begin
        predict_drive(sample, want);
        expected_drives.push_back(want);
      end
    end
    outstanding = expected_drives.size();
  end

endmodule

@@ verif/direction_gain_pid_position_tb.sv @@
`timescale 1ns / 1ps

module direction_gain_pid_position_tb;

  import dgpid_pkg::*;

  localparam int POSITION_BITS  = 32;
  localparam int INTEGRAL_BITS  = 48;
  localparam int PHASE_ITEMS    = 110;
  localparam int HOLD_ITEMS     = 40;
  localparam int HOLD_CYCLES    = 600;
  localparam int SETTLE_CYCLES  = 10;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 4000;

  // index codes past the gain registers, writes there must be dropped
  localparam logic [REG_INDEX_BITS-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [REG_INDEX_BITS-1:0] REG_SPARE_HI = 3'd7;

  localparam gain_t GAIN_MAX = 24'sh7FFFFF;
  localparam gain_t GAIN_MIN = 24'sh800000;

  localparam logic signed [COUNT_BITS-1:0] POS_MAX = 32'sh7FFFFFFF;
  localparam logic signed [COUNT_BITS-1:0] POS_MIN = 32'sh80000000;

  // receiver stall patterns
  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_write = 1'b0;
  logic [REG_INDEX_BITS-1:0] cfg_index = '0;
  logic [GAIN_BITS-1:0]      cfg_data = '0;
  logic                      sample_valid = 1'b0;
  logic                      sample_stall;
  sample_t                   sample = '0;
  logic                      result_valid;
  logic                      result_stall = 1'b0;
  result_t                   result;

  int    mismatches;
  int    outstanding;
  int    idle_cycles;
  int    burst_left;
  bit    hold_req;
  bit    hold_done;
  gain_t gain_plan [6];

  // 4 ns period, high then low
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  direction_gain_pid_position #(
    .POSITION_BITS(POSITION_BITS),
    .INTEGRAL_BITS(INTEGRAL_BITS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  direction_gain_pid_position_checker #(
    .POSITION_BITS(POSITION_BITS),
    .INTEGRAL_BITS(INTEGRAL_BITS)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  // watchdog: any cycle with a word moving on either side resets the count
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("direction_gain_pid_position verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: segments of random stall patterns, plus one long hold-off on request
  initial begin
    rx_mode_t mode;
    int       seg_len;
    @(negedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        // long hold-off so the pipeline fills and the sample side backs up
        hold_done = 1'b1;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        mode    = rx_mode_t'($urandom_range(0, 3));
        seg_len = $urandom_range(10, 200);
        for (int k = 0; k < seg_len; k++) begin
          case (mode)
            RX_OPEN:     result_stall <= 1'b0;
            RX_LIGHT:    result_stall <= ($urandom_range(0, 3) == 0);
            RX_HEAVY:    result_stall <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: result_stall <= ((k % 5) < 2);
            default:     result_stall <= 1'b0;
          endcase
          @(negedge clk);
        end
      end
    end
  end

  // offer one sample word and wait for it to be taken; valid stays high inside a
  // burst, drops for a random gap between bursts
  task automatic send_sample(input sample_t s);
    int gap;
    sample       <= s;
    sample_valid <= 1'b1;
    do @(posedge clk); while (sample_stall);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      sample_valid <= 1'b0;
      repeat (gap) @(negedge clk);
      // now and then a long stretch with no gaps at all
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) : $urandom_range(0, 20);
    end
  endtask

  task automatic send_pair(input logic signed [COUNT_BITS-1:0] tgt,
                           input logic signed [COUNT_BITS-1:0] meas);
    sample_t s;
    s.target_count   = tgt;
    s.measured_count = meas;
    send_sample(s);
  endtask

  // sender pauses until every drive word is back, then lets the pipe go quiet
  task automatic settle();
    sample_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // write all six gains from the plan, then one dropped write to a spare index
  task automatic load_gains();
    for (int i = 0; i < 6; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= i[REG_INDEX_BITS-1:0];
      cfg_data  <= gain_plan[i];
      @(negedge clk);
    end
    cfg_index <= $urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI;
    cfg_data  <= GAIN_BITS'($urandom);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic gain_t small_gain(input int span);
    small_gain = gain_t'($urandom_range(0, 2 * span) - span);
  endfunction

  function automatic logic signed [COUNT_BITS-1:0] pick_corner();
    case ($urandom_range(0, 3))
      0:       pick_corner = POS_MAX;
      1:       pick_corner = POS_MIN;
      2:       pick_corner = '0;
      default: pick_corner = -1;
    endcase
  endfunction

  // mostly a measured position tracking the target closely, so the loop terms
  // stay inside full scale; the rest equal, wide-open or corner positions
  function automatic sample_t random_sample();
    sample_t s;
    int      span;
    int      delta;
    span = 16 << (4 * $urandom_range(0, 2));
    s.target_count   = $urandom;
    s.measured_count = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        delta = $urandom_range(0, 2 * span) - span;
        s.measured_count = s.target_count - delta;
      end
      6: s.measured_count = s.target_count;
      9: begin
        s.target_count   = pick_corner();
        s.measured_count = pick_corner();
      end
      default: ;
    endcase
    random_sample = s;
  endfunction

  initial begin
    burst_left = 0;
    hold_req   = 1'b0;

    // synchronous reset, released on a falling edge
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // gains still at their zero reset value: drive must be zero
    send_pair(32'sd1000, -32'sd1000);
    send_pair(POS_MAX, POS_MIN);
    send_pair(POS_MIN, POS_MAX);
    settle();

    // directed part: distinct up and down sets so the selection shows
    gain_plan[REG_KP_DOWN] = 24'sd256;
    gain_plan[REG_KI_DOWN] = 24'sd1;
    gain_plan[REG_KD_DOWN] = 24'sd64;
    gain_plan[REG_KP_UP]   = 24'sd512;
    gain_plan[REG_KI_UP]   = -24'sd2;
    gain_plan[REG_KD_UP]   = -24'sd128;
    load_gains();
    send_pair(32'sd0, 32'sd0);              // equal positions pick the down set
    send_pair(32'sd100, 32'sd100);
    send_pair(32'sd10, 32'sd0);             // target above: up set
    send_pair(32'sd0, 32'sd10);             // target below: down set
    send_pair(32'sd1000, -32'sd1000);
    send_pair(-32'sd5000, 32'sd3000);       // large swing in the difference term
    send_pair(-32'sd1, 32'sd0);
    send_pair(32'sd0, -32'sd1);
    send_pair(POS_MAX, POS_MIN);            // largest positive error
    send_pair(POS_MIN, POS_MAX);            // largest negative error
    send_pair(POS_MIN, POS_MIN);
    send_pair(POS_MAX, POS_MAX);
    send_pair(32'sd20000, 32'sd19990);
    send_pair(32'sd19990, 32'sd20000);

    // random part, one gain setting per phase
    for (int phase = 0; phase < 9; phase++) begin
      settle();
      foreach (gain_plan[i]) gain_plan[i] = '0;
      case (phase)
        0: foreach (gain_plan[i]) gain_plan[i] = small_gain(512);
        1: foreach (gain_plan[i]) gain_plan[i] = (i % 2 == 0) ? GAIN_MAX : GAIN_MIN;
        2: foreach (gain_plan[i]) gain_plan[i] = (i % 2 == 0) ? GAIN_MIN : GAIN_MAX;
        3: begin
          // proportional only
          gain_plan[REG_KP_DOWN] = small_gain(2048);
          gain_plan[REG_KP_UP]   = small_gain(2048);
        end
        4: begin
          // derivative only
          gain_plan[REG_KD_DOWN] = small_gain(2048);
          gain_plan[REG_KD_UP]   = small_gain(2048);
        end
        5: begin
          // integral only
          gain_plan[REG_KI_DOWN] = small_gain(16);
          gain_plan[REG_KI_UP]   = small_gain(16);
        end
        default: begin
          foreach (gain_plan[i])
            gain_plan[i] = ($urandom_range(0, 3) == 0) ? gain_t'($urandom) : small_gain(1024);
        end
      endcase
      load_gains();
      repeat (PHASE_ITEMS) send_sample(random_sample());
    end

    // back-pressure: receiver holds off while the sender keeps offering
    settle();
    hold_req = 1'b1;
    wait (hold_done);
    burst_left = HOLD_ITEMS;
    repeat (HOLD_ITEMS) send_sample(random_sample());
    settle();

    // integral term alone with full-range errors, first one way, then the other
    foreach (gain_plan[i]) gain_plan[i] = '0;
    gain_plan[REG_KI_DOWN] = 24'sd1;
    gain_plan[REG_KI_UP]   = 24'sd1;
    load_gains();
    repeat (5) send_pair(POS_MIN, POS_MAX);
    repeat (5) send_pair(POS_MAX, POS_MIN);

    // drain, then wait with the pipe quiet to catch any stray word
    sample_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("direction_gain_pid_position verification clean");
    end else begin
      $display("direction_gain_pid_position verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/dgpid_pkg.sv
sv/dgpid_error.sv
sv/direction_gain_pid_position.sv
verif/direction_gain_pid_position_checker.sv
verif/direction_gain_pid_position_tb.sv
